// ----- src/record_table_insert_delete_search_core_macros.svh -----
// ----------------------------------------------------------------------------
// Record table core assertion macros
// Shared concurrent assertion forms used by the record table core.
// ----------------------------------------------------------------------------
`ifndef RECORD_TABLE_INSERT_DELETE_SEARCH_CORE_MACROS_SVH
`define RECORD_TABLE_INSERT_DELETE_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTIDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTIDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/rtids_pkg.sv -----
// ----------------------------------------------------------------------------
// Record table package
// Beat types, record type, cell control and operation/status codes.
// ----------------------------------------------------------------------------
package rtids_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam logic [1:0] OP_SEARCH = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_BAD       = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] key_id;
      logic [4:0]  position;
      logic [7:0]  new_age;
      logic [23:0] new_salary;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  found_index;
      logic [15:0] found_id;
      logic [7:0]  found_age;
      logic [23:0] found_salary;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] key_id;
      logic [7:0]  age;
      logic [23:0] salary;
   } record_type;

   typedef struct packed {
      logic cmp_en;
      logic ins_en;
      logic del_en;
   } cell_ctrl_type;

endpackage

// ----- src/rtids_cell.sv -----
// ----------------------------------------------------------------------------
// Record table cell
// Holds one record, compares its key and shifts with its neighbors.
// ----------------------------------------------------------------------------
module rtids_cell #(
   parameter int IDX   = 0,
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic                   clock,
   input  rtids_pkg::cell_ctrl_type ctrl,
   input  logic [15:0]            key_id,
   input  logic [4:0]             position,
   input  logic [CNT_W-1:0]       count,
   input  rtids_pkg::record_type  new_rec,
   input  rtids_pkg::record_type  left_rec,
   input  rtids_pkg::record_type  right_rec,
   output rtids_pkg::record_type  rec_out,
   input  logic                   below_in,
   output logic                   below_out,
   input  rtids_pkg::record_type  hit_rec_in,
   output rtids_pkg::record_type  hit_rec_out,
   input  logic [IDX_W-1:0]       hit_idx_in,
   output logic [IDX_W-1:0]       hit_idx_out
);
   import rtids_pkg::*;

   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   record_type rec_ff;
   logic       match_ff;
   logic       live;
   logic       first;

   assign live        = MY_CNT < count;
   assign first       = match_ff & ~below_in;
   assign below_out   = below_in | match_ff;
   assign hit_rec_out = first ? rec_ff : hit_rec_in;
   assign hit_idx_out = first ? MY_IDX : hit_idx_in;
   assign rec_out     = rec_ff;

   always_ff @(posedge clock) begin
      if (ctrl.cmp_en) begin
         match_ff <= live && (rec_ff.key_id == key_id);
      end
      if (ctrl.ins_en) begin
         if (int'(position) == IDX) begin
            rec_ff <= new_rec;
         end else if (int'(position) < IDX) begin
            rec_ff <= left_rec;
         end
      end else if (ctrl.del_en) begin
         // close the gap: every cell at or above the first hit pulls from the right
         if (below_out) begin
            rec_ff <= right_rec;
         end
      end
   end

endmodule

// ----- src/record_table_insert_delete_search_core.sv -----
// ----------------------------------------------------------------------------
// Record table core
// Ordered table of records with search, insert at position and delete by key.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry one operation beat (search, insert, delete);
//   rsp_valid/rsp_ready carry exactly one result beat per operation.
//   A beat accepted in the idle step is compared in every cell in the
//   compare step, and the table update and result register are written in
//   the update step; rsp_valid rises when that update commits.
//   One operation is in flight at a time: req_ready returns after the
//   update, so a new beat is taken only once the last one has committed. The
//   update step follows the registered compare pass and carries the ripple of
//   the first-hit flag, index and record through the chain of CAPACITY cells.
//   The result register decouples the sides: a new request is taken while
//   a result still waits. If the receiver stalls with a result pending,
//   the next operation holds in its update step until the result leaves.
//   Reset empties the table (count zero) and drops any pending result;
//   record contents are not cleared and only entries below the count are
//   ever read.
// ----------------------------------------------------------------------------
`include "record_table_insert_delete_search_core_macros.svh"

module record_table_insert_delete_search_core #(
   parameter int CAPACITY = rtids_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rtids_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rtids_pkg::rsp_type rsp_data
);
   import rtids_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0]       state_ff, state_in;
   req_type          req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   cell_ctrl_type    ctrl;
   record_type       new_rec;
   record_type       recs    [CAPACITY];
   logic             below   [CAPACITY+1];
   record_type       hit_rec [CAPACITY+1];
   logic [IDX_W-1:0] hit_idx [CAPACITY+1];

   logic             commit;
   logic             found;
   logic             ins_ok;
   logic [31:0]      hit_idx_wide;
   logic [31:0]      count_wide;

   assign new_rec.key_id = req_ff.key_id;
   assign new_rec.age    = req_ff.new_age;
   assign new_rec.salary = req_ff.new_salary;

   assign below[0]   = 1'b0;
   assign hit_rec[0] = '0;
   assign hit_idx[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      record_type left_rec;
      record_type right_rec;
      if (i == 0) begin : g_head
         assign left_rec = new_rec;
      end else begin : g_mid_l
         assign left_rec = recs[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_rec = recs[i];
      end else begin : g_mid_r
         assign right_rec = recs[i+1];
      end
      rtids_cell #(
         .IDX   (i),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .key_id      (req_ff.key_id),
         .position    (req_ff.position),
         .count       (count_ff),
         .new_rec     (new_rec),
         .left_rec    (left_rec),
         .right_rec   (right_rec),
         .rec_out     (recs[i]),
         .below_in    (below[i]),
         .below_out   (below[i+1]),
         .hit_rec_in  (hit_rec[i]),
         .hit_rec_out (hit_rec[i+1]),
         .hit_idx_in  (hit_idx[i]),
         .hit_idx_out (hit_idx[i+1])
      );
   end

   assign found        = below[CAPACITY];
   assign hit_idx_wide = 32'(hit_idx[CAPACITY]);
   assign ins_ok       = (32'(req_ff.position) <= 32'(count_ff)) && (count_ff < CAP_CNT);
   assign commit       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      ctrl        = '0;
      ctrl.cmp_en = (state_ff == S_CMP);
      count_in    = count_ff;
      rsp_in      = '0;
      rsp_in.status = ST_BAD;
      case (req_ff.operation)
         OP_SEARCH: begin
            if (found) begin
               rsp_in.status       = ST_OK;
               rsp_in.found_index  = hit_idx_wide[3:0];
               rsp_in.found_id     = hit_rec[CAPACITY].key_id;
               rsp_in.found_age    = hit_rec[CAPACITY].age;
               rsp_in.found_salary = hit_rec[CAPACITY].salary;
            end else begin
               rsp_in.status = ST_NOT_FOUND;
            end
         end
         OP_INSERT: begin
            if (ins_ok) begin
               ctrl.ins_en        = commit;
               count_in           = count_ff + CNT_W'(1);
               rsp_in.status      = ST_OK;
               rsp_in.found_index = req_ff.position[3:0];
            end
         end
         OP_DELETE: begin
            if (found) begin
               ctrl.del_en        = commit;
               count_in           = count_ff - CNT_W'(1);
               rsp_in.status      = ST_OK;
               rsp_in.found_index = hit_idx_wide[3:0];
            end else begin
               rsp_in.status = ST_NOT_FOUND;
            end
         end
         default: begin
            rsp_in.status = ST_BAD;
         end
      endcase
      count_wide         = 32'(count_in);
      rsp_in.entry_count = count_wide[4:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // hold until the result register is free
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   `RTIDS_ASSERT_NOW(a_count_cap, clock, reset, 1'b1, count_ff <= CAP_CNT,
                     "live count above capacity")
   `RTIDS_ASSERT_NEXT(a_count_hold, clock, reset, state_ff != S_EXEC, $stable(count_ff),
                      "live count changed outside the update step")
   `RTIDS_ASSERT_NEXT(a_accept_cmp, clock, reset, req_valid && req_ready, state_ff == S_CMP,
                      "accepted beat did not enter the compare step")
   `RTIDS_ASSERT_NEXT(a_rsp_drain, clock, reset, rsp_valid && rsp_ready && !commit, !rsp_valid,
                      "result beat repeated after it was taken")

endmodule

// ----- tb/tb_record_table_insert_delete_search_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record table core testbench
// Drives search, insert and delete beats into the core with bursty traffic
// and a stalling receiver. A shadow table in the testbench computes each
// expected result on acceptance, and the monitor compares every result beat
// field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb_record_table_insert_delete_search_core;
   import rtids_pkg::*;

   localparam int         CAPACITY   = CAPACITY_DEF;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   typedef struct packed {
      logic    drain;
      req_type item;
   } pend_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   record_table_insert_delete_search_core #(.CAPACITY(CAPACITY)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stimulus queue and the key list that the generator keeps in step with it.
   pend_type    pending_q[$];
   logic [15:0] gen_keys[$];

   // Shadow of the table contents, and the results still owed by the core.
   record_type  shadow_tbl[CAPACITY];
   logic [4:0]  shadow_cnt = '0;
   rsp_type     owed_q[$];

   int sent_cnt     = 0;
   int accepted_cnt = 0;
   int err_cnt      = 0;
   int n_search     = 0;
   int n_insert     = 0;
   int n_delete     = 0;
   int n_reject     = 0;
   int n_full       = 0;

   function automatic rsp_type apply_op(req_type r);
      rsp_type res;
      int      hit;
      res        = '0;
      res.status = ST_BAD;
      hit        = -1;
      case (r.operation)
         OP_SEARCH, OP_DELETE: begin
            for (int i = 0; i < shadow_cnt; i++)
               if (hit < 0 && shadow_tbl[i].key_id == r.key_id) hit = i;
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else if (r.operation == OP_SEARCH) begin
               res.status       = ST_OK;
               res.found_index  = hit[3:0];
               res.found_id     = shadow_tbl[hit].key_id;
               res.found_age    = shadow_tbl[hit].age;
               res.found_salary = shadow_tbl[hit].salary;
            end else begin
               for (int k = hit; k + 1 < shadow_cnt; k++) shadow_tbl[k] = shadow_tbl[k + 1];
               shadow_cnt      = shadow_cnt - 1'b1;
               res.status      = ST_OK;
               res.found_index = hit[3:0];
            end
         end
         OP_INSERT: begin
            if (r.position <= shadow_cnt && shadow_cnt < CAPACITY) begin
               for (int i = shadow_cnt; i > r.position; i--) shadow_tbl[i] = shadow_tbl[i - 1];
               shadow_tbl[r.position] = '{key_id: r.key_id, age: r.new_age,
                                          salary: r.new_salary};
               shadow_cnt      = shadow_cnt + 1'b1;
               res.status      = ST_OK;
               res.found_index = r.position[3:0];
            end
         end
         default: ;
      endcase
      res.entry_count = shadow_cnt;
      return res;
   endfunction

   // Queue one beat and keep the generator's key list in step.
   task automatic push_item(logic [1:0] op, logic [15:0] key, logic [4:0] pos,
                            logic [7:0] age, logic [23:0] sal, logic drain);
      pend_type p;
      int       hit;
      p.drain = drain;
      p.item  = '{operation: op, key_id: key, position: pos, new_age: age, new_salary: sal};
      pending_q.push_back(p);
      hit = -1;
      if (op == OP_INSERT && pos <= gen_keys.size() && gen_keys.size() < CAPACITY)
         gen_keys.insert(pos, key);
      if (op == OP_DELETE) begin
         foreach (gen_keys[i]) if (hit < 0 && gen_keys[i] == key) hit = i;
         if (hit >= 0) gen_keys.delete(hit);
      end
   endtask

   function automatic logic [15:0] pick_key();
      if (gen_keys.size() != 0 && $urandom_range(0, 9) < 8)
         return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
      return $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 7)) : 16'($urandom);
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%t %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
         err_cnt++;
      end
   endtask

   // Driver: bursts of beats separated by random gaps.
   int burst_left = 8;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && sent_cnt != accepted_cnt)) begin
         if (pending_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_q[0].drain && owed_q.size() != 0) begin
            req_valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data  <= pending_q[0].item;
            void'(pending_q.pop_front());
            sent_cnt++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = $urandom_range(0, 3) == 0 ? $urandom_range(5, 12)
                                                      : $urandom_range(0, 2);
            end
         end
      end
   end

   // Receiver: changing stall pattern, plus one long hold-off midway.
   int  hold_left = 0;
   bit  hold_done = 0;
   int  mode      = 0;
   int  mode_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_cnt >= 250) begin
         hold_done = 1;
         hold_left = 300;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 80);
         end else begin
            mode_left--;
         end
         case (mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (mode_left % 5 != 0);
         endcase
      end
   end

   // Monitor: predict on request beats, check result beats.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               $display("%t unexpected result beat: expected none, actual %0h", $time, rsp_data);
               err_cnt++;
            end else begin
               want = owed_q.pop_front();
               check_field("status",       32'(want.status),       32'(rsp_data.status));
               check_field("found_index",  32'(want.found_index),  32'(rsp_data.found_index));
               check_field("found_id",     32'(want.found_id),     32'(rsp_data.found_id));
               check_field("found_age",    32'(want.found_age),    32'(rsp_data.found_age));
               check_field("found_salary", 32'(want.found_salary), 32'(rsp_data.found_salary));
               check_field("entry_count",  32'(want.entry_count),  32'(rsp_data.entry_count));
            end
         end
         if (req_valid && req_ready) begin
            want = apply_op(req_data);
            owed_q.push_back(want);
            accepted_cnt++;
            case (req_data.operation)
               OP_SEARCH: n_search++;
               OP_INSERT: n_insert++;
               OP_DELETE: n_delete++;
               default:   ;
            endcase
            if (want.status == ST_BAD) n_reject++;
            if (shadow_cnt == CAPACITY) n_full++;
         end
      end
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      bit         filling;
      int         phase_left;
      int         roll;
      logic [1:0] op;
      logic [4:0] pos;

      // Directed: empty table, bad positions, unknown op, duplicates, full table.
      push_item(OP_SEARCH,  16'h0000, 5'd0,  8'h00, 24'h000000, 1'b0);
      push_item(OP_DELETE,  16'hFFFF, 5'd0,  8'hFF, 24'hFFFFFF, 1'b0);
      push_item(OP_INSERT,  16'h0001, 5'd1,  8'h01, 24'h000001, 1'b0);
      push_item(OP_UNKNOWN, 16'hFFFF, 5'd31, 8'hFF, 24'hFFFFFF, 1'b0);
      push_item(OP_INSERT,  16'hFFFF, 5'd0,  8'hFF, 24'hFFFFFF, 1'b0);
      push_item(OP_INSERT,  16'h0000, 5'd0,  8'h00, 24'h000000, 1'b0);
      push_item(OP_INSERT,  16'h1234, 5'd2,  8'h12, 24'h123456, 1'b0);
      push_item(OP_INSERT,  16'h1234, 5'd1,  8'h34, 24'h654321, 1'b0);
      push_item(OP_SEARCH,  16'h1234, 5'd0,  8'h00, 24'h000000, 1'b0);
      push_item(OP_DELETE,  16'h1234, 5'd0,  8'h00, 24'h000000, 1'b0);
      push_item(OP_SEARCH,  16'hFFFF, 5'd0,  8'h00, 24'h000000, 1'b0);
      while (gen_keys.size() < CAPACITY)
         push_item(OP_INSERT, 16'(16'h0100 + gen_keys.size()),
                   5'($urandom_range(0, gen_keys.size())), 8'($urandom),
                   24'($urandom), 1'b0);
      push_item(OP_INSERT, 16'hBEEF, 5'd16, 8'hAA, 24'h555555, 1'b0);
      push_item(OP_SEARCH, gen_keys[CAPACITY - 1], 5'd0, 8'h00, 24'h000000, 1'b0);
      push_item(OP_DELETE, gen_keys[0], 5'd0, 8'h00, 24'h000000, 1'b0);

      // Random: alternate fill and drain phases so the count sweeps both ends.
      filling    = 1;
      phase_left = $urandom_range(20, 60);
      for (int n = 0; n < 650; n++) begin
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            push_item(OP_UNKNOWN, 16'($urandom), 5'($urandom), 8'($urandom),
                      24'($urandom), n == 450);
         end else if (roll < 8) begin
            push_item(2'($urandom_range(0, 2)), 16'($urandom), 5'($urandom),
                      8'($urandom), 24'($urandom), n == 450);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 60 : 20))      op = OP_INSERT;
            else if (roll < (filling ? 85 : 45)) op = OP_SEARCH;
            else                                 op = OP_DELETE;
            if ($urandom_range(0, 9) == 0) pos = 5'($urandom_range(gen_keys.size(), 31));
            else                           pos = 5'($urandom_range(0, gen_keys.size()));
            push_item(op, op == OP_INSERT && $urandom_range(0, 1) ? 16'($urandom) : pick_key(),
                      pos, 8'($urandom), 24'($urandom), n == 450);
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || sent_cnt != accepted_cnt) @(posedge clock);
      while (owed_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (owed_q.size() != 0) begin
         $display("%t %0d results never arrived", $time, owed_q.size());
         err_cnt++;
      end

      $display("Ran %0d beats: %0d searches, %0d inserts, %0d deletes, %0d rejected",
               accepted_cnt, n_search, n_insert, n_delete, n_reject);
      $display("Table was full after %0d operations; %0d errors", n_full, err_cnt);
      if (err_cnt == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/rtids_pkg.sv
src/rtids_cell.sv
src/record_table_insert_delete_search_core.sv
tb/tb_record_table_insert_delete_search_core.sv
